@@ hdl/irpwbr_pkg.sv @@
// irpwbr_pkg: shared types and constants for the ir pulse-width byte receiver
// transaction payload structs and configuration register indexes
// no dependencies
`timescale 1ns / 1ps

package irpwbr_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_DEVICE_ADDRESS  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_UNIT_TICKS      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TOLERANCE_TICKS = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_RED_BIT         = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_GREEN_BIT       = 3'd4;

  // input event kinds
  localparam logic KIND_EDGE     = 1'b0;
  localparam logic KIND_OVERFLOW = 1'b1;

  typedef struct packed {
    logic       kind;
    logic       line_level;
    logic [7:0] interval_ticks;
    logic       green_button_down;
    logic       red_button_down;
  } in_item_t;

  typedef struct packed {
    logic       red_led;
    logic       grn_led;
    logic       byte_done;
    logic [7:0] received_byte;
  } out_item_t;

endpackage

@@ hdl/ir_pulse_width_byte_receiver.sv @@
// ir_pulse_width_byte_receiver: one-pass decoder for infrared pulse-width frames
// throughput: one transaction per cycle while the output is not stalled
// decoding is short combinational logic between the input handshake and an output register
// a one-entry skid register keeps the input open while a result waits on output stall
// reset (rst_ni low, asynchronous): decoder idle, leds off, registers at their defaults
`timescale 1ns / 1ps

module ir_pulse_width_byte_receiver (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [irpwbr_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [irpwbr_pkg::CfgDataW-1:0]     cfg_wdata_i,
  // event input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  irpwbr_pkg::in_item_t                in_data_i,
  // result output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output irpwbr_pkg::out_item_t               out_data_o
);

  // frame phase codes
  localparam logic [1:0] FP_START_MARK  = 2'd0;
  localparam logic [1:0] FP_START_SPACE = 2'd1;
  localparam logic [1:0] FP_DATA        = 2'd2;

  // byte phase codes
  localparam logic [1:0] BP_WAIT_ADDR = 2'd0;
  localparam logic [1:0] BP_MATCHED   = 2'd1;
  localparam logic [1:0] BP_IGNORE    = 2'd2;

  // configuration registers
  logic [7:0] device_address_q;
  logic [5:0] unit_ticks_q;
  logic [4:0] tolerance_ticks_q;
  logic [2:0] red_bit_q;
  logic [2:0] green_bit_q;

  // decoder state
  logic       timer_running_q, timer_running_d;
  logic [1:0] frame_phase_q, frame_phase_d;
  logic [1:0] byte_phase_q, byte_phase_d;
  logic [7:0] shift_byte_q, shift_byte_d;
  logic [3:0] bit_count_q, bit_count_d;
  logic [7:0] mark_length_q, mark_length_d;
  logic       red_drive_q, red_drive_d;
  logic       green_drive_q, green_drive_d;

  // output register and skid stage
  logic                  out_valid_q;
  irpwbr_pkg::out_item_t out_data_q;
  logic                  skid_valid_q;
  irpwbr_pkg::out_item_t skid_data_q;
  irpwbr_pkg::out_item_t result_d;

  logic in_accept;
  logic out_fire;

  assign in_stall_o  = skid_valid_q;
  assign in_accept   = in_valid_i & ~skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_fire    = out_valid_q & ~out_stall_i;

  // ticks lie below n*unit - tolerance (a negative bound holds no ticks)
  function automatic logic win_below(input logic [7:0] t, input logic [1:0] n,
                                     input logic [5:0] unit, input logic [4:0] tol);
    logic [9:0] nom;
    nom = 10'(n) * 10'(unit);
    return (10'(t) + 10'(tol)) < nom;
  endfunction

  // ticks lie above n*unit + tolerance
  function automatic logic win_above(input logic [7:0] t, input logic [1:0] n,
                                     input logic [5:0] unit, input logic [4:0] tol);
    logic [9:0] nom;
    nom = 10'(n) * 10'(unit);
    return 10'(t) > (nom + 10'(tol));
  endfunction

  // configuration writes, indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_address_q  <= 8'd0;
      unit_ticks_q      <= 6'd6;
      tolerance_ticks_q <= 5'd2;
      red_bit_q         <= 3'd0;
      green_bit_q       <= 3'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        irpwbr_pkg::CFG_DEVICE_ADDRESS:  device_address_q  <= cfg_wdata_i;
        irpwbr_pkg::CFG_UNIT_TICKS:      unit_ticks_q      <= cfg_wdata_i[5:0];
        irpwbr_pkg::CFG_TOLERANCE_TICKS: tolerance_ticks_q <= cfg_wdata_i[4:0];
        irpwbr_pkg::CFG_RED_BIT:         red_bit_q         <= cfg_wdata_i[2:0];
        irpwbr_pkg::CFG_GREEN_BIT:       green_bit_q       <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  // single-pass decode of one event
  always_comb begin
    logic       t_below1;
    logic       t_above2;
    logic       t_in1;
    logic       t_in2;
    logic       t_in3;
    logic       m_in1;
    logic       m_in2;
    logic       done;
    logic [7:0] got;

    timer_running_d = timer_running_q;
    frame_phase_d   = frame_phase_q;
    byte_phase_d    = byte_phase_q;
    shift_byte_d    = shift_byte_q;
    bit_count_d     = bit_count_q;
    mark_length_d   = mark_length_q;
    red_drive_d     = red_drive_q;
    green_drive_d   = green_drive_q;
    done            = 1'b0;
    got             = 8'd0;

    // window checks on the interval and on the recorded mark
    t_below1 = win_below(in_data_i.interval_ticks, 2'd1, unit_ticks_q, tolerance_ticks_q);
    t_above2 = win_above(in_data_i.interval_ticks, 2'd2, unit_ticks_q, tolerance_ticks_q);
    t_in1 = ~t_below1 &
            ~win_above(in_data_i.interval_ticks, 2'd1, unit_ticks_q, tolerance_ticks_q);
    t_in2 = ~t_above2 &
            ~win_below(in_data_i.interval_ticks, 2'd2, unit_ticks_q, tolerance_ticks_q);
    t_in3 = ~win_below(in_data_i.interval_ticks, 2'd3, unit_ticks_q, tolerance_ticks_q) &
            ~win_above(in_data_i.interval_ticks, 2'd3, unit_ticks_q, tolerance_ticks_q);
    m_in1 = ~win_below(mark_length_q, 2'd1, unit_ticks_q, tolerance_ticks_q) &
            ~win_above(mark_length_q, 2'd1, unit_ticks_q, tolerance_ticks_q);
    m_in2 = ~win_below(mark_length_q, 2'd2, unit_ticks_q, tolerance_ticks_q) &
            ~win_above(mark_length_q, 2'd2, unit_ticks_q, tolerance_ticks_q);

    if (in_data_i.kind == irpwbr_pkg::KIND_OVERFLOW) begin
      timer_running_d = 1'b0;
    end else if (in_data_i.green_button_down) begin
      green_drive_d = 1'b1;
      red_drive_d   = 1'b0;
    end else if (in_data_i.red_button_down) begin
      red_drive_d   = 1'b1;
      green_drive_d = 1'b0;
    end else if (!timer_running_q) begin
      // first edge after overflow only restarts timing
      timer_running_d = 1'b1;
    end else begin
      case (frame_phase_q)
        FP_START_MARK: begin
          if (in_data_i.line_level && t_in3) frame_phase_d = FP_START_SPACE;
        end
        FP_START_SPACE: begin
          frame_phase_d = (!in_data_i.line_level && t_in3) ? FP_DATA : FP_START_MARK;
        end
        FP_DATA: begin
          // interval outside both data windows resets the decoder
          if (t_below1 || t_above2) begin
            shift_byte_d  = 8'd0;
            bit_count_d   = 4'd0;
            frame_phase_d = FP_START_MARK;
            byte_phase_d  = BP_WAIT_ADDR;
          end
          if (!in_data_i.line_level) begin
            if (t_in1 && m_in2) begin
              shift_byte_d = {shift_byte_d[6:0], 1'b1};
              bit_count_d  = bit_count_d + 4'd1;
            end else if (t_in2 && m_in1) begin
              shift_byte_d = {shift_byte_d[6:0], 1'b0};
              bit_count_d  = bit_count_d + 4'd1;
            end else begin
              shift_byte_d  = 8'd0;
              bit_count_d   = 4'd0;
              frame_phase_d = FP_START_MARK;
              byte_phase_d  = BP_WAIT_ADDR;
            end
            if (bit_count_d == 4'd8) begin
              done = 1'b1;
              got  = shift_byte_d;
              // address match, then one data byte, then ignore
              case (byte_phase_d)
                BP_WAIT_ADDR: begin
                  byte_phase_d = (shift_byte_d == device_address_q) ? BP_MATCHED
                                                                    : BP_WAIT_ADDR;
                end
                BP_MATCHED: begin
                  red_drive_d   = shift_byte_d[red_bit_q];
                  green_drive_d = shift_byte_d[green_bit_q];
                  byte_phase_d  = BP_IGNORE;
                end
                default: ;
              endcase
              shift_byte_d = 8'd0;
              bit_count_d  = 4'd0;
            end
          end else begin
            // a mark just ended: keep its length for the pair check
            mark_length_d = in_data_i.interval_ticks;
          end
        end
        default: ;
      endcase
    end

    result_d.red_led       = red_drive_d;
    result_d.grn_led       = green_drive_d;
    result_d.byte_done     = done;
    result_d.received_byte = got;
  end

  // decoder state advances on every accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_running_q <= 1'b0;
      frame_phase_q   <= FP_START_MARK;
      byte_phase_q    <= BP_WAIT_ADDR;
      shift_byte_q    <= 8'd0;
      bit_count_q     <= 4'd0;
      mark_length_q   <= 8'd0;
      red_drive_q     <= 1'b0;
      green_drive_q   <= 1'b0;
    end else if (in_accept) begin
      timer_running_q <= timer_running_d;
      frame_phase_q   <= frame_phase_d;
      byte_phase_q    <= byte_phase_d;
      shift_byte_q    <= shift_byte_d;
      bit_count_q     <= bit_count_d;
      mark_length_q   <= mark_length_d;
      red_drive_q     <= red_drive_d;
      green_drive_q   <= green_drive_d;
    end
  end

  // output register with skid stage behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_accept;
      end
    end else if (in_accept) begin
      // output held by stall: park the new result
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_data_q <= skid_data_q;
      end else if (in_accept) begin
        out_data_q <= result_d;
      end
    end else if (in_accept) begin
      skid_data_q <= result_d;
    end
  end

  // a parked result always has one ahead of it
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_valid_q |-> out_valid_q)
    else $error("skid entry held without a result in the output register");

  // a stalled output with a parked result must stop the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && out_stall_i && skid_valid_q) |=> in_stall_o)
    else $error("input opened while both result slots were full");

  // the byte count wraps at eight, so it never rests at eight or above
  assert property (@(posedge clk_i) disable iff (!rst_ni) bit_count_q < 4'd8)
    else $error("bit count left at or above eight");

  // no completed byte means an all-zero byte field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && !out_data_q.byte_done) |-> (out_data_q.received_byte == 8'd0))
    else $error("received byte set without byte done");

endmodule
